/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros used by the sampler core RTL.
// Each macro builds one labeled concurrent assertion that is disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when a holds, c holds in the same cycle.
`define TGS_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("tgs assertion failed");

// Next-cycle implication: when a holds, c holds in the next cycle.
`define TGS_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("tgs assertion failed");

`endif

/* rtl/tgs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgs_pkg
// Shared types, constants and the blend function of the grid sampler.
// ----------------------------------------------------------------------------
package tgs_pkg;

  // Default sizing of the grid.
  localparam int unsigned AXIS_MAX_DEF   = 32;
  localparam int unsigned GRID_CELLS_DEF = 4096;

  // Six occlusion channels per cell: +x, -x, +y, -y, +z, -z.
  localparam int unsigned CHANNELS = 6;
  localparam int unsigned CH_POS_X = 0;
  localparam int unsigned CH_NEG_X = 1;
  localparam int unsigned CH_POS_Y = 2;
  localparam int unsigned CH_NEG_Y = 3;
  localparam int unsigned CH_POS_Z = 4;
  localparam int unsigned CH_NEG_Z = 5;

  // Value 1.0 in unsigned Q1.15.
  localparam logic [15:0] ONE_Q15 = 16'h8000;

  typedef logic [15:0] chan_t;
  typedef logic [CHANNELS-1:0][15:0] chan_vec_t;

  // Item kinds.
  typedef enum logic {
    KIND_WRITE  = 1'b0,
    KIND_SAMPLE = 1'b1
  } kind_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_ORIGIN_Z = 3'd2,
    CFG_INV_CELL = 3'd3,
    CFG_CELLS_X  = 3'd4,
    CFG_CELLS_Y  = 3'd5,
    CFG_CELLS_Z  = 3'd6
  } cfg_reg_e;

  // Linear blend with round to nearest: (a*(65536-t) + b*t + 32768) >> 16,
  // rewritten as a + floor(((b-a)*t + 32768) / 65536) so one multiply does it.
  function automatic chan_t lerp(input chan_t a, input chan_t b, input logic [15:0] t);
    logic signed [16:0] diff;
    logic signed [33:0] prod;
    logic signed [33:0] step;
    logic [33:0]        sum;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    prod = diff * $signed({1'b0, t});
    step = (prod + 34'sd32768) >>> 16;
    sum  = $unsigned(step) + {18'd0, a};
    return sum[15:0];
  endfunction

endpackage

/* rtl/tgs_intf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sampler channel interfaces
// Input item channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------

// Input items: a cell write or a sample position.
interface tgs_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [11:0]        cell_index;
  logic [15:0]        wr_pos_x;
  logic [15:0]        wr_neg_x;
  logic [15:0]        wr_pos_y;
  logic [15:0]        wr_neg_y;
  logic [15:0]        wr_pos_z;
  logic [15:0]        wr_neg_z;

  modport source (
    output valid, kind, pos_x, pos_y, pos_z, cell_index,
    output wr_pos_x, wr_neg_x, wr_pos_y, wr_neg_y, wr_pos_z, wr_neg_z,
    input  ready
  );
  modport sink (
    input  valid, kind, pos_x, pos_y, pos_z, cell_index,
    input  wr_pos_x, wr_neg_x, wr_pos_y, wr_neg_y, wr_pos_z, wr_neg_z,
    output ready
  );
endinterface

// Result items: six interpolated channels.
interface tgs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_pos_x;
  logic [15:0] out_neg_x;
  logic [15:0] out_pos_y;
  logic [15:0] out_neg_y;
  logic [15:0] out_pos_z;
  logic [15:0] out_neg_z;

  modport source (
    output valid, out_pos_x, out_neg_x, out_pos_y, out_neg_y, out_pos_z, out_neg_z,
    input  ready
  );
  modport sink (
    input  valid, out_pos_x, out_neg_x, out_pos_y, out_neg_y, out_pos_z, out_neg_z,
    output ready
  );
endinterface

// Configuration writes: register index and data.
interface tgs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/tgs_axis_map.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgs_axis_map
// Four-stage pipeline mapping one position coordinate to clamped low and
// high grid corners and a 16-bit blend fraction.
// ----------------------------------------------------------------------------
module tgs_axis_map #(
  parameter int unsigned AXIS_MAX = tgs_pkg::AXIS_MAX_DEF,
  localparam int unsigned CntW = $clog2(AXIS_MAX + 1),
  localparam int unsigned IdxW = (AXIS_MAX > 1) ? $clog2(AXIS_MAX) : 1
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] pos_i,
  input  logic signed [31:0] origin_i,
  input  logic [31:0]        inv_i,
  input  logic [CntW-1:0]    count_i,
  output logic [IdxW-1:0]    lo_o,
  output logic [IdxW-1:0]    hi_o,
  output logic [15:0]        frac_o
);
  import tgs_pkg::*;

  logic [32:0]     diff_d, diff_q;
  logic [31:0]     mag_d, mag_q;
  logic            neg_b_q, neg_c_q;
  logic [63:0]     prod_d, prod_q;
  logic [31:0]     whole, fr, fr_neg;
  logic [CntW-1:0] nm1, lo_ext;
  logic [IdxW-1:0] lo_d, hi_d, lo_q, hi_q;
  logic [15:0]     frac_d, frac_q;

  // Stage one: signed distance from the grid origin.
  assign diff_d = {pos_i[31], pos_i} - {origin_i[31], origin_i};

  // Stage two: magnitude and sign.
  assign mag_d = diff_q[32] ? 32'(~diff_q + 33'd1) : diff_q[31:0];

  // Stage three: scale by the inverse cell size, exact in Q.32.
  assign prod_d = mag_q * inv_i;

  // Stage four: floor, clamp to the grid and fraction.
  assign whole  = prod_q[63:32];
  assign fr     = prod_q[31:0];
  assign fr_neg = 32'd0 - fr;
  assign nm1    = count_i - CntW'(1);
  assign frac_d = (neg_c_q && (fr != 32'd0)) ? fr_neg[31:16] : fr[31:16];

  always_comb begin
    // A negative distance always floors to a cell at or below zero.
    if (neg_c_q) begin
      lo_d = '0;
    end else if (whole > 32'(nm1)) begin
      lo_d = IdxW'(nm1);
    end else begin
      lo_d = IdxW'(whole);
    end
    lo_ext = CntW'(lo_d) + CntW'(1);
    hi_d   = (lo_ext > nm1) ? IdxW'(nm1) : IdxW'(lo_ext);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      diff_q  <= diff_d;
      mag_q   <= mag_d;
      neg_b_q <= diff_q[32];
      prod_q  <= prod_d;
      neg_c_q <= neg_b_q;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      frac_q  <= frac_d;
    end
  end

  assign lo_o   = lo_q;
  assign hi_o   = hi_q;
  assign frac_o = frac_q;

endmodule

/* rtl/tgs_grid_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgs_grid_mem
// One copy of the cell store: one write port and two registered read ports.
// ----------------------------------------------------------------------------
module tgs_grid_mem #(
  parameter int unsigned GRID_CELLS = tgs_pkg::GRID_CELLS_DEF,
  localparam int unsigned AddrW = $clog2(GRID_CELLS)
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic               we_i,
  input  logic [AddrW-1:0]   waddr_i,
  input  tgs_pkg::chan_vec_t wdata_i,
  input  logic [AddrW-1:0]   raddr_a_i,
  input  logic [AddrW-1:0]   raddr_b_i,
  output tgs_pkg::chan_vec_t rdata_a_o,
  output tgs_pkg::chan_vec_t rdata_b_o
);
  import tgs_pkg::*;

  chan_vec_t mem [GRID_CELLS];
  chan_vec_t rd_a_q, rd_b_q;

  // Reads and the write move only when the pipeline advances.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[waddr_i] <= wdata_i;
      end
      rd_a_q <= mem[raddr_a_i];
      rd_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rd_a_q;
  assign rdata_b_o = rd_b_q;

endmodule

/* rtl/trilinear_grid_sampler_core.sv */
// A result is presented from the output register once its sample item has passed
// every stage. Throughput: one item per cycle unless a finished result is held
// up; the axis multiplier and blend stages are fully pipelined and each corner
// pair is read from its own store copy. Reset clears the valid bits and configuration;
// grid contents stay undefined until written, and no clearing pass is run.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trilinear_grid_sampler_core
// Nine-stage trilinear sampler over a 3D grid of six-channel cells.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module trilinear_grid_sampler_core #(
  parameter int unsigned AXIS_MAX   = tgs_pkg::AXIS_MAX_DEF,
  parameter int unsigned GRID_CELLS = tgs_pkg::GRID_CELLS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tgs_in_if.sink     in_if,
  tgs_out_if.source  out_if,
  tgs_cfg_if.sink    cfg_if
);
  import tgs_pkg::*;

  localparam int unsigned CntW  = $clog2(AXIS_MAX + 1);
  localparam int unsigned IdxW  = (AXIS_MAX > 1) ? $clog2(AXIS_MAX) : 1;
  localparam int unsigned AreaW = $clog2(AXIS_MAX * AXIS_MAX + 1);
  localparam int unsigned TotW  = $clog2(AXIS_MAX * AXIS_MAX * AXIS_MAX + 1);
  localparam int unsigned AddrW = $clog2(GRID_CELLS);

  typedef struct packed {
    logic vld;
    logic sample;
    logic empty;
  } ctl_t;

  typedef struct packed {
    logic [11:0] idx;
    chan_vec_t   data;
  } wr_t;

  // Configuration registers.
  logic signed [31:0] origin_x_q, origin_y_q, origin_z_q;
  logic [31:0]        inv_cell_q;
  logic [5:0]         cells_x_q, cells_y_q, cells_z_q;
  logic [CntW-1:0]    cnt_x, cnt_y, cnt_z;
  logic [AreaW-1:0]   area_q;
  logic [TotW-1:0]    total_q;

  // Pipeline control and payload.
  logic              adv;
  logic              in_xfer;
  ctl_t              ctl_q [1:9];
  wr_t               wr_q [1:5];
  logic [IdxW-1:0]   xl, xh, yl, yh, zl, zh;
  logic [15:0]       tx, ty, tz;
  logic [2:0][15:0]  t5_q, t6_q, t7_q, t8_q;
  logic [TotW-1:0]   xs [2];
  logic [TotW-1:0]   ys [2];
  logic [TotW-1:0]   zs [2];
  logic [TotW-1:0]   addr_d [8];
  logic [TotW-1:0]   addr_q [8];
  logic [7:0]        oob_q;
  logic              we;
  chan_vec_t         rd [8];
  chan_vec_t         q_d [4];
  chan_vec_t         q_q [4];
  chan_vec_t         p_d [2];
  chan_vec_t         p_q [2];
  chan_vec_t         out_d, out_q;

  // Configuration writes are always taken.
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      origin_z_q <= '0;
      inv_cell_q <= 32'd65536;
      cells_x_q  <= '0;
      cells_y_q  <= '0;
      cells_z_q  <= '0;
    end else if (cfg_if.valid) begin
      unique case (cfg_reg_e'(cfg_if.index))
        CFG_ORIGIN_X: origin_x_q <= $signed(cfg_if.data);
        CFG_ORIGIN_Y: origin_y_q <= $signed(cfg_if.data);
        CFG_ORIGIN_Z: origin_z_q <= $signed(cfg_if.data);
        CFG_INV_CELL: inv_cell_q <= cfg_if.data;
        CFG_CELLS_X:  cells_x_q  <= cfg_if.data[5:0];
        CFG_CELLS_Y:  cells_y_q  <= cfg_if.data[5:0];
        CFG_CELLS_Z:  cells_z_q  <= cfg_if.data[5:0];
        default: ;
      endcase
    end
  end

  // Axis counts saturate at the largest supported size.
  assign cnt_x = (32'(cells_x_q) > AXIS_MAX) ? CntW'(AXIS_MAX) : CntW'(cells_x_q);
  assign cnt_y = (32'(cells_y_q) > AXIS_MAX) ? CntW'(AXIS_MAX) : CntW'(cells_y_q);
  assign cnt_z = (32'(cells_z_q) > AXIS_MAX) ? CntW'(AXIS_MAX) : CntW'(cells_z_q);

  // Slice area is registered from the counts, and the cell total from the slice area.
  always_ff @(posedge clk_i) begin
    area_q  <= AreaW'(cnt_x) * AreaW'(cnt_y);
    total_q <= TotW'(area_q) * TotW'(cnt_z);
  end

  // The whole pipeline advances unless a finished result is held up.
  assign adv          = !ctl_q[9].vld || out_if.ready;
  assign in_if.ready  = adv;
  assign in_xfer      = in_if.valid && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 1; s <= 9; s++) begin
        ctl_q[s] <= '0;
      end
    end else if (adv) begin
      ctl_q[1].vld    <= in_xfer;
      ctl_q[1].sample <= (kind_e'(in_if.kind) == KIND_SAMPLE);
      ctl_q[1].empty  <= (cnt_x == '0) || (cnt_y == '0) || (cnt_z == '0);
      for (int s = 2; s <= 9; s++) begin
        if (s != 6) begin
          ctl_q[s] <= ctl_q[s-1];
        end
      end
      // Write items retire at the store and never reach the output.
      ctl_q[6].vld    <= ctl_q[5].vld && ctl_q[5].sample;
      ctl_q[6].sample <= ctl_q[5].sample;
      ctl_q[6].empty  <= ctl_q[5].empty;
    end
  end

  // Write payload travels alongside the axis stages.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      wr_q[1].idx  <= in_if.cell_index;
      wr_q[1].data <= {in_if.wr_neg_z, in_if.wr_pos_z, in_if.wr_neg_y,
                       in_if.wr_pos_y, in_if.wr_neg_x, in_if.wr_pos_x};
      for (int s = 2; s <= 5; s++) begin
        wr_q[s] <= wr_q[s-1];
      end
    end
  end

  // Stages one to four: coordinate mapping per axis.
  tgs_axis_map #(.AXIS_MAX(AXIS_MAX)) u_map_x (
    .clk_i, .en_i(adv), .pos_i(in_if.pos_x), .origin_i(origin_x_q),
    .inv_i(inv_cell_q), .count_i(cnt_x), .lo_o(xl), .hi_o(xh), .frac_o(tx)
  );
  tgs_axis_map #(.AXIS_MAX(AXIS_MAX)) u_map_y (
    .clk_i, .en_i(adv), .pos_i(in_if.pos_y), .origin_i(origin_y_q),
    .inv_i(inv_cell_q), .count_i(cnt_y), .lo_o(yl), .hi_o(yh), .frac_o(ty)
  );
  tgs_axis_map #(.AXIS_MAX(AXIS_MAX)) u_map_z (
    .clk_i, .en_i(adv), .pos_i(in_if.pos_z), .origin_i(origin_z_q),
    .inv_i(inv_cell_q), .count_i(cnt_z), .lo_o(zl), .hi_o(zh), .frac_o(tz)
  );

  // Stage five: flat corner addresses, corner k takes x from bit 2,
  // y from bit 1 and z from bit 0.
  always_comb begin
    xs[0] = TotW'(xl);
    xs[1] = TotW'(xh);
    ys[0] = TotW'(yl) * TotW'(cnt_x);
    ys[1] = TotW'(yh) * TotW'(cnt_x);
    zs[0] = TotW'(zl) * TotW'(area_q);
    zs[1] = TotW'(zh) * TotW'(area_q);
    for (int k = 0; k < 8; k++) begin
      addr_d[k] = xs[(k >> 2) & 1] + ys[(k >> 1) & 1] + zs[k & 1];
    end
  end

  // Addresses and out-of-store flags are registered, and fractions follow their item down to the blend stages.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 8; k++) begin
        addr_q[k] <= addr_d[k];
        oob_q[k]  <= (32'(addr_q[k]) >= GRID_CELLS);
      end
      t5_q <= {tz, ty, tx};
      t6_q <= t5_q;
      t7_q <= t6_q;
      t8_q <= t7_q;
    end
  end

  // A write lands in every store copy when its cell lies inside the grid and the store.
  assign we = adv && ctl_q[5].vld && !ctl_q[5].sample
              && (32'(wr_q[5].idx) < 32'(total_q))
              && (32'(wr_q[5].idx) < GRID_CELLS);

  // Stage six: each copy serves the low-x and high-x corner of one y/z pair.
  for (genvar j = 0; j < 4; j++) begin : g_mem
    tgs_grid_mem #(.GRID_CELLS(GRID_CELLS)) u_mem (
      .clk_i,
      .en_i(adv),
      .we_i(we),
      .waddr_i(AddrW'(wr_q[5].idx)),
      .wdata_i(wr_q[5].data),
      .raddr_a_i(AddrW'(addr_q[j])),
      .raddr_b_i(AddrW'(addr_q[j+4])),
      .rdata_a_o(rd[j]),
      .rdata_b_o(rd[j+4])
    );
  end

  // Stage seven: blend along x; corners beyond the store read as zero.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int c = 0; c < CHANNELS; c++) begin
        q_d[k][c] = lerp(oob_q[k] ? 16'd0 : rd[k][c],
                         oob_q[k+4] ? 16'd0 : rd[k+4][c], t6_q[0]);
      end
    end
  end

  // Stage eight: blend along y.
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      for (int c = 0; c < CHANNELS; c++) begin
        p_d[k][c] = lerp(q_q[k][c], q_q[k+2][c], t7_q[1]);
      end
    end
  end

  // Stage nine: blend along z, or 1.0 everywhere for an empty grid.
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      out_d[c] = ctl_q[8].empty ? ONE_Q15 : lerp(p_q[0][c], p_q[1][c], t8_q[2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      q_q   <= q_d;
      p_q   <= p_d;
      out_q <= out_d;
    end
  end

  // Result channel.
  assign out_if.valid     = ctl_q[9].vld;
  assign out_if.out_pos_x = out_q[CH_POS_X];
  assign out_if.out_neg_x = out_q[CH_NEG_X];
  assign out_if.out_pos_y = out_q[CH_POS_Y];
  assign out_if.out_neg_y = out_q[CH_NEG_Y];
  assign out_if.out_pos_z = out_q[CH_POS_Z];
  assign out_if.out_neg_z = out_q[CH_NEG_Z];

  // Input back-pressure only comes from a held result.
  `TGS_ASSERT_IMP(a_ready_only_on_hold, clk_i, rst_ni, !in_if.ready,
                  out_if.valid && !out_if.ready)
  // A sample on an empty grid comes out as 1.0.
  `TGS_ASSERT_NXT(a_empty_gives_one, clk_i, rst_ni,
                  adv && ctl_q[8].vld && ctl_q[8].empty,
                  out_if.valid && out_if.out_pos_x == ONE_Q15 && out_if.out_neg_z == ONE_Q15)
  // A new result appears only after the pipeline moved.
  `TGS_ASSERT_IMP(a_result_after_advance, clk_i, rst_ni, $rose(out_if.valid), $past(adv))

endmodule

/* tb/trilinear_grid_sampler_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trilinear grid sampler testbench
// Drives cell writes and sample positions through several grid settings,
// predicts every interpolated result in a scoreboard and checks each result
// transfer field by field, under random idling on both sides.
// ----------------------------------------------------------------------------
module trilinear_grid_sampler_core_test;
  import tgs_pkg::*;

  localparam int unsigned STORE_CELLS = GRID_CELLS_DEF;

  // One input item as the testbench sees it.
  typedef struct {
    kind_e            kind;
    logic [2:0][31:0] pos;
    logic [11:0]      cell_index;
    chan_vec_t        wr;
  } grid_item_t;

  // Scoreboard: shadow configuration and grid, queue of expected blends.
  class grid_scoreboard;
    longint      origin [3];
    logic [63:0] inv_cell;
    longint      cells [3];
    logic [15:0] cell_mem [STORE_CELLS][CHANNELS];
    bit          written [STORE_CELLS];
    chan_vec_t   blend_q [$];
    int          mismatches;
    int          results_seen;
    int          samples;
    int          writes;

    function new();
      origin = '{0, 0, 0};
      inv_cell = 64'd65536;
      cells = '{0, 0, 0};
      foreach (written[i]) written[i] = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [31:0] val);
      case (idx)
        CFG_ORIGIN_X: origin[0] = longint'($signed(val));
        CFG_ORIGIN_Y: origin[1] = longint'($signed(val));
        CFG_ORIGIN_Z: origin[2] = longint'($signed(val));
        CFG_INV_CELL: inv_cell = {32'd0, val};
        CFG_CELLS_X:  cells[0] = val[5:0];
        CFG_CELLS_Y:  cells[1] = val[5:0];
        CFG_CELLS_Z:  cells[2] = val[5:0];
        default: ;
      endcase
    endfunction

    function longint axis(int a);
      return (cells[a] > AXIS_MAX_DEF) ? longint'(AXIS_MAX_DEF) : cells[a];
    endfunction

    function longint total_cells();
      return axis(0) * axis(1) * axis(2);
    endfunction

    function int pending();
      return blend_q.size();
    endfunction

    // Position to clamped corners and a 16-bit fraction; the product wraps at
    // 64 bits like the fixed-point datapath definition.
    function void map_axis(input logic [31:0] p, input longint org, input longint n,
                           output longint lo, output longint hi, output longint t);
      longint      diff;
      logic [63:0] mag;
      logic [63:0] prod;
      logic [63:0] fr;
      longint      whole;
      longint      cellv;
      diff = longint'($signed(p)) - org;
      mag = (diff < 0) ? 64'(-diff) : 64'(diff);
      prod = mag * inv_cell;
      whole = longint'(prod >> 32);
      fr = {32'd0, prod[31:0]};
      if (diff >= 0) begin
        cellv = whole;
      end else if (fr == 0) begin
        cellv = -whole;
      end else begin
        cellv = -whole - 1;
        fr = 64'h1_0000_0000 - fr;
      end
      t = longint'(fr >> 16);
      if (cellv < 0) lo = 0;
      else if (cellv > n - 1) lo = n - 1;
      else lo = cellv;
      hi = (lo + 1 > n - 1) ? n - 1 : lo + 1;
    endfunction

    function longint mix(longint a, longint b, longint t);
      return (a * (65536 - t) + b * t + 32768) >>> 16;
    endfunction

    function longint read_cell(longint idx, int ch);
      if (idx >= STORE_CELLS) return 0;
      return cell_mem[idx][ch];
    endfunction

    // Called at each input transfer.
    function void note_item(grid_item_t it);
      longint    tot;
      longint    lo [3];
      longint    hi [3];
      longint    t [3];
      longint    c [8];
      longint    q [4];
      longint    p0;
      longint    p1;
      longint    idx;
      chan_vec_t res;
      tot = total_cells();
      if (it.kind == KIND_WRITE) begin
        writes++;
        if (it.cell_index < tot && it.cell_index < STORE_CELLS) begin
          for (int ch = 0; ch < CHANNELS; ch++) cell_mem[it.cell_index][ch] = it.wr[ch];
          written[it.cell_index] = 1;
        end
        return;
      end
      samples++;
      if (tot == 0) begin
        for (int ch = 0; ch < CHANNELS; ch++) res[ch] = ONE_Q15;
        blend_q.push_back(res);
        return;
      end
      for (int a = 0; a < 3; a++) map_axis(it.pos[a], origin[a], axis(a), lo[a], hi[a], t[a]);
      for (int ch = 0; ch < CHANNELS; ch++) begin
        for (int k = 0; k < 8; k++) begin
          idx = (k[2] ? hi[0] : lo[0]) + (k[1] ? hi[1] : lo[1]) * axis(0)
              + (k[0] ? hi[2] : lo[2]) * axis(0) * axis(1);
          c[k] = read_cell(idx, ch);
        end
        for (int k = 0; k < 4; k++) q[k] = mix(c[k], c[k + 4], t[0]);
        p0 = mix(q[0], q[2], t[1]);
        p1 = mix(q[1], q[3], t[1]);
        res[ch] = 16'(mix(p0, p1, t[2]));
      end
      blend_q.push_back(res);
    endfunction

    // Called at each result transfer.
    function void check_result(chan_vec_t got);
      chan_vec_t want;
      results_seen++;
      if (blend_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        mismatches++;
        return;
      end
      want = blend_q.pop_front();
      for (int ch = 0; ch < CHANNELS; ch++) begin
        if (got[ch] !== want[ch]) begin
          $display("%0t: channel %0d expected %h actual %h", $time, ch, want[ch], got[ch]);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  tgs_in_if  in_bus ();
  tgs_out_if out_bus ();
  tgs_cfg_if cfg_bus ();

  trilinear_grid_sampler_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_bus.sink),
    .out_if (out_bus.source),
    .cfg_if (cfg_bus.sink)
  );

  grid_scoreboard sb = new();

  int idle_pct;
  int stall_pct;
  bit hold_req;
  int hold_left;
  int phases_run;

  // Clock.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Run limit.
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Result side: check each transfer, then pick the next ready level.
  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      sb.check_result({out_bus.out_neg_z, out_bus.out_pos_z, out_bus.out_neg_y,
                       out_bus.out_pos_y, out_bus.out_neg_x, out_bus.out_pos_x});
    end
    if (hold_req) begin
      hold_req = 0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Send one item and wait for its transfer.
  task automatic send_item(grid_item_t it);
    if ($urandom_range(99) < idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
    in_bus.valid      <= 1'b1;
    in_bus.kind       <= it.kind;
    in_bus.pos_x      <= it.pos[0];
    in_bus.pos_y      <= it.pos[1];
    in_bus.pos_z      <= it.pos[2];
    in_bus.cell_index <= it.cell_index;
    in_bus.wr_pos_x   <= it.wr[CH_POS_X];
    in_bus.wr_neg_x   <= it.wr[CH_NEG_X];
    in_bus.wr_pos_y   <= it.wr[CH_POS_Y];
    in_bus.wr_neg_y   <= it.wr[CH_NEG_Y];
    in_bus.wr_pos_z   <= it.wr[CH_POS_Z];
    in_bus.wr_neg_z   <= it.wr[CH_NEG_Z];
    do @(posedge clk_i); while (!in_bus.ready);
    sb.note_item(it);
  endtask

  function automatic chan_vec_t rand_channels(bit full_range);
    chan_vec_t v;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      v[ch] = full_range ? 16'($urandom) : 16'($urandom_range(32768));
    end
    return v;
  endfunction

  task automatic write_cell(int idx, chan_vec_t vals);
    grid_item_t it;
    it.kind = KIND_WRITE;
    it.pos = {3{32'($urandom)}};
    it.cell_index = 12'(idx);
    it.wr = vals;
    send_item(it);
  endtask

  task automatic sample_at(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    grid_item_t it;
    it.kind = KIND_SAMPLE;
    it.pos = {z, y, x};
    it.cell_index = 12'($urandom);
    it.wr = rand_channels(1);
    send_item(it);
  endtask

  // A coordinate mostly within one cell of the grid, sometimes on a
  // cell boundary, sometimes anywhere.
  function automatic logic [31:0] rand_coord(int a);
    longint edge_len;
    longint n;
    longint off;
    int     pick;
    edge_len = longint'(64'h1_0000_0000 / sb.inv_cell);
    n = sb.axis(a);
    pick = $urandom_range(99);
    if (pick < 15) return 32'($urandom);
    if (pick < 35) off = (longint'($urandom_range(n + 2)) - 1) * edge_len;
    else off = longint'($urandom_range(1000)) * (n + 2) * edge_len / 1000 - edge_len;
    return 32'(sb.origin[a] + off);
  endfunction

  task automatic random_item();
    longint tot;
    int     idx;
    tot = sb.total_cells();
    if ($urandom_range(99) < 25) begin
      if (tot > 0 && $urandom_range(99) < 80)
        idx = $urandom_range((tot > STORE_CELLS ? STORE_CELLS : tot) - 1);
      else idx = $urandom_range(4095);
      write_cell(idx, rand_channels($urandom_range(99) < 20));
    end else begin
      sample_at(rand_coord(0), rand_coord(1), rand_coord(2));
    end
  endtask

  // Stop offering items, then let every expected result arrive and the
  // pipeline empty out.
  task automatic drain();
    in_bus.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  // Write all seven registers back to back while the block is idle.
  task automatic configure(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                           logic [31:0] inv, int cx, int cy, int cz);
    logic [31:0] vals [7];
    vals = '{ox, oy, oz, inv, 32'(cx), 32'(cy), 32'(cz)};
    for (int i = 0; i < 7; i++) begin
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= cfg_reg_e'(i);
      cfg_bus.data  <= vals[i];
      do @(posedge clk_i); while (!cfg_bus.ready);
      sb.set_reg(cfg_reg_e'(i), vals[i]);
    end
    cfg_bus.valid <= 1'b0;
  endtask

  // Write every in-range cell that has never been written.
  task automatic fill_grid();
    longint tot;
    tot = sb.total_cells();
    if (tot > STORE_CELLS) tot = STORE_CELLS;
    for (int i = 0; i < tot; i++) begin
      if (!sb.written[i]) write_cell(i, rand_channels($urandom_range(99) < 10));
    end
  endtask

  task automatic set_idling(int mode);
    case (mode % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 85; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 85; end
      default: begin idle_pct = 24; stall_pct = 24; end
    endcase
  endtask

  task automatic run_phase(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                           logic [31:0] inv, int cx, int cy, int cz, int mode, int count);
    drain();
    configure(ox, oy, oz, inv, cx, cy, cz);
    phases_run++;
    set_idling(mode);
    fill_grid();
    repeat (count) random_item();
  endtask

  initial begin
    rst_ni = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    hold_left = 0;
    phases_run = 0;
    in_bus.valid = 1'b0;
    in_bus.kind = KIND_WRITE;
    in_bus.pos_x = '0;
    in_bus.pos_y = '0;
    in_bus.pos_z = '0;
    in_bus.cell_index = '0;
    in_bus.wr_pos_x = '0;
    in_bus.wr_neg_x = '0;
    in_bus.wr_pos_y = '0;
    in_bus.wr_neg_y = '0;
    in_bus.wr_pos_z = '0;
    in_bus.wr_neg_z = '0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CFG_ORIGIN_X;
    cfg_bus.data = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty grid after reset: writes are dropped, samples answer 1.0.
    write_cell(0, rand_channels(1));
    sample_at(32'h0, 32'h0, 32'h0);
    sample_at(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_8000);
    sample_at(32'hFFFF_FFFF, 32'h0, 32'h8000_0000);

    // Two by two by two grid with unit cells: directed corners and fractions.
    drain();
    configure(32'h0, 32'h0, 32'h0, 32'h0001_0000, 2, 2, 2);
    phases_run++;
    write_cell(0, '0);
    write_cell(1, {6{ONE_Q15}});
    write_cell(2, {6{16'hFFFF}});
    write_cell(3, rand_channels(0));
    write_cell(4, {16'h0, 16'hFFFF, 16'h8000, 16'h0001, 16'h7FFF, 16'h1234});
    write_cell(5, rand_channels(1));
    write_cell(6, rand_channels(0));
    write_cell(7, rand_channels(1));
    write_cell(8, rand_channels(1));
    write_cell(4095, rand_channels(1));
    sample_at(32'h0, 32'h0, 32'h0);
    sample_at(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
    sample_at(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    sample_at(32'h0001_FFFF, 32'h0000_0001, 32'h0000_C000);
    sample_at(32'hFFFF_8000, 32'hFFFF_0000, 32'hFFFF_FFFF);
    sample_at(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    sample_at(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    sample_at(32'h0005_4321, 32'hFFFE_0001, 32'h0000_4000);
    set_idling(0);
    repeat (60) random_item();

    // Extremes of the registers.
    run_phase(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h1, 40, 1, 3, 1, 60);
    run_phase(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, 1, 1, 2, 60);

    // A grid larger than the store: samples straddle the last stored layer,
    // so their upper corners read as zero, while the receiver holds off.
    drain();
    configure(32'h0, 32'h0, 32'h0, 32'h0001_0000, 32, 32, 5);
    phases_run++;
    set_idling(0);
    for (int y = 0; y < 3; y++) begin
      for (int x = 0; x < 3; x++) begin
        write_cell(3072 + x + 32 * y, rand_channels($urandom_range(99) < 20));
      end
    end
    hold_req = 1;
    repeat (100) begin
      sample_at(32'($urandom_range(32'h1_FFFF)), 32'($urandom_range(32'h1_FFFF)),
                32'h0003_0000 + 32'($urandom_range(32'h2_0000)));
    end
    run_phase(32'h0, 32'h0, 32'h0, 32'h0001_0000, 4, 0, 3, 3, 60);

    // Random small grids through every idling pattern.
    for (int p = 0; p < 4; p++) begin
      run_phase(32'($urandom_range(65536 * 8)) - 32'h0004_0000,
                32'($urandom), 32'($urandom_range(32'hFFFF)),
                32'($urandom_range(32'h2000, 32'h80000)),
                $urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 8), p, 60);
    end

    drain();
    $display("Ran %0d grid settings: %0d samples and %0d cell writes, %0d results checked",
             phases_run, sb.samples, sb.writes, sb.results_seen);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
